// ----- rtl/core/dqs_pkg.sv -----
package dqs_pkg;

   // Default depth of the queue
   localparam int unsigned CAPACITY_DEFAULT = 32;
   localparam int unsigned DATA_W = 32;

   // Command codes carried by an input item
   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_SEARCH     = 3'd4,
      MODE_DUMP       = 3'd5
   } mode_type;

   // Result codes
   typedef enum logic [2:0] {
      KIND_FOUND   = 3'd0,
      KIND_MISSING = 3'd1,
      KIND_EMPTY   = 3'd2,
      KIND_ENTRY   = 3'd3,
      KIND_FULL    = 3'd4
   } kind_type;

   // What every cell of the row does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_RIGHT,
      CELL_SHIFT_LEFT,
      CELL_LOAD_BACK,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DUMP
   } state_type;

   // Control broadcast along the row
   typedef struct packed {
      cell_op_type             op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/dqs_channel_if.sv -----
// Command channel
interface dqs_req_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          mode;
   logic signed [dqs_pkg::DATA_W-1:0]   value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

// Result channel
interface dqs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          kind;
   logic signed [dqs_pkg::DATA_W-1:0]   entry;
   logic                                last;

   modport source (output valid, output kind, output entry, output last, input ready);
   modport sink (input valid, input kind, input entry, input last, output ready);
endinterface

// ----- rtl/core/dqs_cell.sv -----
// One slot of the queue; cell INDEX holds the entry INDEX places from the front
module dqs_cell #(
   parameter int unsigned CAPACITY = dqs_pkg::CAPACITY_DEFAULT,
   parameter int unsigned INDEX    = 0
) (
   input  logic                                 clock,
   input  dqs_pkg::cell_ctrl_type               ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]        count,
   input  logic signed [dqs_pkg::DATA_W-1:0]    left_data,
   input  logic signed [dqs_pkg::DATA_W-1:0]    right_data,
   input  logic signed [dqs_pkg::DATA_W-1:0]    head_data,
   output logic signed [dqs_pkg::DATA_W-1:0]    data
);

   localparam int unsigned CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] IDX      = CW'(INDEX);
   localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

   logic signed [dqs_pkg::DATA_W-1:0] data_ff;
   logic signed [dqs_pkg::DATA_W-1:0] data_in;

   // Next content of the slot
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         dqs_pkg::CELL_SHIFT_RIGHT: data_in = left_data;
         dqs_pkg::CELL_SHIFT_LEFT:  data_in = right_data;
         dqs_pkg::CELL_LOAD_BACK: begin
            if (count == IDX) data_in = ctrl.value;
         end
         dqs_pkg::CELL_ROTATE: begin
            // live cells move one place to the front, the head wraps to the tail
            if (count > IDX_NEXT) data_in = right_data;
            else if (count == IDX_NEXT) data_in = head_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/core/deque_with_search_core.sv -----
// Bounded double-ended queue of signed 32-bit values, kept in a row of CAPACITY cells
// ordered front to back. A push or pop gives no item back, except a push onto a full queue,
// which gives one item of kind full. Search and dump rotate the row once round its live
// entries, one place a cycle unless a step waits for the output register (search answers
// once at the end, dump gives one item per entry, the final one marked last); on an empty
// queue either gives a single empty item. Only one command is in work at a time, and the
// rotation length sets the rate. A single output register sits between the cells and the
// result channel; while it holds an item the receiver has not taken, no new command is
// accepted and a rotation waits wherever it needs to hand over an item.
module deque_with_search_core #(
   parameter int unsigned CAPACITY = dqs_pkg::CAPACITY_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   dqs_req_if.sink       req_if,
   dqs_rsp_if.source     rsp_if
);

   localparam int unsigned CW = $clog2(CAPACITY+1);
   localparam int unsigned SW = $clog2(CAPACITY);

   dqs_pkg::state_type                 state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [SW-1:0]                      step_ff, step_in;
   logic                               hit_ff, hit_in;
   logic signed [dqs_pkg::DATA_W-1:0]  key_ff, key_in;

   logic                               rsp_valid_ff;
   dqs_pkg::kind_type                  rsp_kind_ff;
   logic signed [dqs_pkg::DATA_W-1:0]  rsp_entry_ff;
   logic                               rsp_last_ff;

   logic                               rsp_load;
   dqs_pkg::kind_type                  load_kind;
   logic signed [dqs_pkg::DATA_W-1:0]  load_entry;
   logic                               load_last;

   dqs_pkg::cell_ctrl_type             cell_ctrl;
   logic signed [dqs_pkg::DATA_W-1:0]  cell_data [CAPACITY];
   logic signed [dqs_pkg::DATA_W-1:0]  head;

   logic                               out_free;
   logic                               is_full;
   logic                               is_empty;
   logic                               is_final;
   logic                               match;
   logic [CW-1:0]                      count_dec;

   assign head      = cell_data[0];
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - CW'(1);
   assign is_final  = (step_ff == count_dec[SW-1:0]);
   assign match     = hit_ff || (head == key_ff);

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [dqs_pkg::DATA_W-1:0] left_data;
      logic signed [dqs_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cell_ctrl.value;
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end

      dqs_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (head),
         .data       (cell_data[i])
      );
   end

   // Sequencer: commands, rotation for search and dump
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      step_in         = step_ff;
      hit_in          = hit_ff;
      key_in          = key_ff;
      cell_ctrl.op    = dqs_pkg::CELL_HOLD;
      cell_ctrl.value = req_if.value;
      req_if.ready    = 1'b0;
      rsp_load        = 1'b0;
      load_kind       = dqs_pkg::KIND_FOUND;
      load_entry      = '0;
      load_last       = 1'b1;

      unique case (state_ff)
         dqs_pkg::ST_IDLE: begin
            req_if.ready = out_free;
            if (req_if.valid && out_free) begin
               unique case (dqs_pkg::mode_type'(req_if.mode))
                  dqs_pkg::MODE_PUSH_FRONT,
                  dqs_pkg::MODE_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_load  = 1'b1;
                        load_kind = dqs_pkg::KIND_FULL;
                     end else begin
                        cell_ctrl.op = (dqs_pkg::mode_type'(req_if.mode) ==
                                        dqs_pkg::MODE_PUSH_FRONT) ?
                                       dqs_pkg::CELL_SHIFT_RIGHT : dqs_pkg::CELL_LOAD_BACK;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  dqs_pkg::MODE_POP_FRONT: begin
                     if (!is_empty) begin
                        cell_ctrl.op = dqs_pkg::CELL_SHIFT_LEFT;
                        count_in     = count_dec;
                     end
                  end
                  dqs_pkg::MODE_POP_BACK: begin
                     if (!is_empty) count_in = count_dec;
                  end
                  dqs_pkg::MODE_SEARCH: begin
                     if (is_empty) begin
                        rsp_load  = 1'b1;
                        load_kind = dqs_pkg::KIND_EMPTY;
                     end else begin
                        state_in = dqs_pkg::ST_SEARCH;
                        key_in   = req_if.value;
                        step_in  = '0;
                        hit_in   = 1'b0;
                     end
                  end
                  dqs_pkg::MODE_DUMP: begin
                     if (is_empty) begin
                        rsp_load  = 1'b1;
                        load_kind = dqs_pkg::KIND_EMPTY;
                     end else begin
                        state_in = dqs_pkg::ST_DUMP;
                        step_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         dqs_pkg::ST_SEARCH: begin
            // compare the head, then rotate; the last step waits for the output
            if (!is_final || out_free) begin
               cell_ctrl.op = dqs_pkg::CELL_ROTATE;
               if (is_final) begin
                  rsp_load  = 1'b1;
                  load_kind = match ? dqs_pkg::KIND_FOUND : dqs_pkg::KIND_MISSING;
                  state_in  = dqs_pkg::ST_IDLE;
               end else begin
                  hit_in  = match;
                  step_in = step_ff + SW'(1);
               end
            end
         end
         dqs_pkg::ST_DUMP: begin
            // one entry out per step, rotating the row back into place
            if (out_free) begin
               cell_ctrl.op = dqs_pkg::CELL_ROTATE;
               rsp_load     = 1'b1;
               load_kind    = dqs_pkg::KIND_ENTRY;
               load_entry   = head;
               load_last    = is_final;
               if (is_final) state_in = dqs_pkg::ST_IDLE;
               else step_in = step_ff + SW'(1);
            end
         end
         default: state_in = dqs_pkg::ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqs_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      hit_ff  <= hit_in;
      key_ff  <= key_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff  <= load_kind;
         rsp_entry_ff <= load_entry;
         rsp_last_ff  <= load_last;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind  = rsp_kind_ff;
   assign rsp_if.entry = rsp_entry_ff;
   assign rsp_if.last  = rsp_last_ff;

   // Checks
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != dqs_pkg::ST_IDLE |-> !req_if.ready)
      else $error("command taken while a search or dump is running");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && !is_full &&
      (req_if.mode == dqs_pkg::MODE_PUSH_FRONT || req_if.mode == dqs_pkg::MODE_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the queue");

   a_not_last_is_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_kind_ff == dqs_pkg::KIND_ENTRY)
      else $error("non-final item that is not a dumped entry");

   a_search_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == dqs_pkg::ST_SEARCH && state_in == dqs_pkg::ST_IDLE
      |=> rsp_valid_ff && rsp_last_ff)
      else $error("search ended without an answer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != dqs_pkg::ST_IDLE |-> !is_empty && count_ff <= CW'(CAPACITY))
      else $error("queue count out of range during rotation");

endmodule
